>>> src/gcev_pkg.sv
// Package for the gamepad change event generator.
// Holds the report, event and work descriptor types and the event codes.
// No dependencies.
`default_nettype none

package gcev_pkg;

    localparam logic [1:0] EV_CONNECT    = 2'd0;
    localparam logic [1:0] EV_DISCONNECT = 2'd1;
    localparam logic [1:0] EV_BUTTON     = 2'd2;
    localparam logic [1:0] EV_AXIS       = 2'd3;

    localparam logic [1:0] AX_LTRIG  = 2'd0;
    localparam logic [1:0] AX_RTRIG  = 2'd1;
    localparam logic [1:0] AX_LTHUMB = 2'd2;
    localparam logic [1:0] AX_RTHUMB = 2'd3;

    // pending-event bit positions, in emit order
    localparam int PEND_W    = 21;
    localparam int PB_CONN   = 0;
    localparam int PB_BTN0   = 1;
    localparam int PB_BTN15  = 16;
    localparam int PB_LTRIG  = 17;
    localparam int PB_RTRIG  = 18;
    localparam int PB_LTHUMB = 19;
    localparam int PB_RTHUMB = 20;
    localparam int PB_W      = 5;

    typedef struct packed {
        logic [1:0]         pad_index;
        logic               pad_present;
        logic [31:0]        packet_number;
        logic [15:0]        buttons;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic signed [15:0] left_thumb_x;
        logic signed [15:0] left_thumb_y;
        logic signed [15:0] right_thumb_x;
        logic signed [15:0] right_thumb_y;
    } t_report;

    typedef struct packed {
        logic [31:0]        pad_uid;
        logic [1:0]         event_kind;
        logic [3:0]         button_index;
        logic               button_down;
        logic [1:0]         axis_id;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic               last;
    } t_event;

    typedef struct packed {
        logic [31:0] packet;
        logic [15:0] buttons;
        logic [7:0]  ltrig;
        logic [7:0]  rtrig;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
    } t_rec;

    typedef struct packed {
        logic [31:0]       uid;
        logic              connect;
        logic [PEND_W-1:0] pend;
        t_rec              rec;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

>>> src/gcev_front.sv
// Front end: per-pad state, report compare and work descriptor build.
// Depends on gcev_pkg.
`default_nettype none

module gcev_front #(
    parameter int PAD_COUNT = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  gcev_pkg::t_report    i_report,
    output logic                 o_push,
    output gcev_pkg::t_desc      o_desc
);
    import gcev_pkg::*;

    localparam int PIW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    logic              r_conn [PAD_COUNT];
    logic [31:0]       r_id   [PAD_COUNT];
    t_rec              r_prev [PAD_COUNT];
    logic [31:0]       r_ctr;
    logic [31:0]       n_ctr;

    logic [PIW-1:0]    w_idx;
    logic              w_hit;
    logic              w_conn;
    logic [31:0]       w_id;
    t_rec              w_old;
    t_rec              w_rec;
    logic              w_upd;
    logic              w_new;
    logic              w_disc;
    logic [PEND_W-1:0] w_pend;

    always_comb begin
        w_idx = PIW'(i_report.pad_index);
        w_hit = (32'(i_report.pad_index) < PAD_COUNT);
        w_conn = r_conn[w_idx];
        w_id   = r_id[w_idx];
        w_old  = r_prev[w_idx];
        n_ctr  = r_ctr + 32'd1;

        w_rec.packet  = i_report.packet_number;
        w_rec.buttons = i_report.buttons;
        w_rec.ltrig   = i_report.left_trigger;
        w_rec.rtrig   = i_report.right_trigger;
        w_rec.lx      = i_report.left_thumb_x;
        w_rec.ly      = i_report.left_thumb_y;
        w_rec.rx      = i_report.right_thumb_x;
        w_rec.ry      = i_report.right_thumb_y;

        w_upd  = w_hit && i_report.pad_present;
        w_new  = w_upd && !w_conn;
        w_disc = w_hit && !i_report.pad_present && w_conn;

        w_pend = '0;
        w_pend[PB_CONN] = w_new || w_disc;
        if (w_upd) begin
            w_pend[PB_BTN15:PB_BTN0] = w_rec.buttons ^ w_old.buttons;
            w_pend[PB_LTRIG]  = (w_rec.ltrig != w_old.ltrig);
            w_pend[PB_RTRIG]  = (w_rec.rtrig != w_old.rtrig);
            w_pend[PB_LTHUMB] = (w_rec.lx != w_old.lx) || (w_rec.ly != w_old.ly);
            w_pend[PB_RTHUMB] = (w_rec.rx != w_old.rx) || (w_rec.ry != w_old.ry);
        end

        o_desc.uid     = w_new ? n_ctr : w_id;
        o_desc.connect = i_report.pad_present;
        o_desc.pend    = w_pend;
        o_desc.rec     = w_rec;
        o_push         = i_accept && (|w_pend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            for (int i = 0; i < PAD_COUNT; i++) begin
                r_conn[i] <= 1'b0;
                r_id[i]   <= '0;
                r_prev[i] <= '0;
            end
        end else if (i_accept && w_hit) begin
            if (i_report.pad_present) begin
                r_conn[w_idx] <= 1'b1;
                r_prev[w_idx] <= w_rec;
                if (w_new) begin
                    r_id[w_idx] <= n_ctr;
                    r_ctr       <= n_ctr;
                end
            end else begin
                r_conn[w_idx] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/gcev_queue.sv
// Two-entry queue of work descriptors between front and back end.
// Depends on gcev_pkg.
`default_nettype none

module gcev_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  gcev_pkg::t_desc  i_desc,
    input  wire logic        i_pop,
    output gcev_pkg::t_desc  o_desc,
    output gcev_pkg::t_qstat o_stat
);
    import gcev_pkg::*;

    t_desc      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        o_stat.full  = (r_cnt == 2'd2);
        o_stat.empty = (r_cnt == 2'd0);
        o_desc       = r_mem[r_rp];
        w_wr         = i_push && !o_stat.full;
        w_rd         = i_pop && !o_stat.empty;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10: r_cnt <= r_cnt + 2'd1;
                2'b01: r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/gcev_back.sv
// Back end: walks the pending-event mask of one descriptor, one beat a cycle
// while the output register is empty or being popped, into the output register. Depends on gcev_pkg.
`default_nettype none

module gcev_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  gcev_pkg::t_desc  i_desc,
    input  gcev_pkg::t_qstat i_qstat,
    output logic             o_qpop,
    input  wire logic        i_pop,
    output logic             o_empty,
    output gcev_pkg::t_event o_event
);
    import gcev_pkg::*;

    t_desc             r_cur;
    logic [PEND_W-1:0] r_pend;
    logic              r_ovld;
    t_event            r_out;

    logic [PEND_W-1:0] w_low;
    logic [PEND_W-1:0] w_rest;
    logic [PB_W-1:0]   w_bit;
    logic [3:0]        w_bidx;
    logic              w_busy;
    logic              w_emit;
    logic              w_load;
    t_event            w_ev;

    always_comb begin
        w_busy = |r_pend;
        w_low  = r_pend & (~r_pend + PEND_W'(1));
        w_rest = r_pend & ~w_low;
        w_bit  = '0;
        for (int i = 0; i < PEND_W; i++) begin
            if (w_low[i]) begin
                w_bit = PB_W'(i);
            end
        end
        w_bidx = 4'(w_bit - PB_W'(PB_BTN0));
        w_emit = w_busy && (!r_ovld || i_pop);
        w_load = !i_qstat.empty && (!w_busy || (w_emit && (w_rest == '0)));
        o_qpop = w_load;

        w_ev = '0;
        w_ev.pad_uid = r_cur.uid;
        w_ev.last    = (w_rest == '0);
        case (w_bit) inside
            PB_CONN: begin
                w_ev.event_kind = r_cur.connect ? EV_CONNECT : EV_DISCONNECT;
            end
            [PB_BTN0:PB_BTN15]: begin
                w_ev.event_kind   = EV_BUTTON;
                w_ev.button_index = w_bidx;
                w_ev.button_down  = r_cur.rec.buttons[w_bidx];
            end
            PB_LTRIG: begin
                w_ev.event_kind = EV_AXIS;
                w_ev.axis_id    = AX_LTRIG;
                w_ev.axis_x     = {8'd0, r_cur.rec.ltrig};
            end
            PB_RTRIG: begin
                w_ev.event_kind = EV_AXIS;
                w_ev.axis_id    = AX_RTRIG;
                w_ev.axis_x     = {8'd0, r_cur.rec.rtrig};
            end
            PB_LTHUMB: begin
                w_ev.event_kind = EV_AXIS;
                w_ev.axis_id    = AX_LTHUMB;
                w_ev.axis_x     = r_cur.rec.lx;
                w_ev.axis_y     = r_cur.rec.ly;
            end
            PB_RTHUMB: begin
                w_ev.event_kind = EV_AXIS;
                w_ev.axis_id    = AX_RTHUMB;
                w_ev.axis_x     = r_cur.rec.rx;
                w_ev.axis_y     = r_cur.rec.ry;
            end
            default: begin
                w_ev.event_kind = EV_CONNECT;
            end
        endcase

        o_empty = !r_ovld;
        o_event = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_desc;
        end
        if (w_emit) begin
            r_out <= w_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (w_load) begin
                r_pend <= i_desc.pend;
            end else if (w_emit) begin
                r_pend <= w_rest;
            end
            if (w_emit) begin
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/gamepad_change_event_generator_top.sv
// Top level of the gamepad change event generator: front end, descriptor
// queue and back end. Depends on gcev_pkg, gcev_front, gcev_queue, gcev_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   report   | push in,  full out   | i_report (gcev_pkg::t_report)
//   event    | pop in,   empty out  | o_event  (gcev_pkg::t_event)
//
// A report is taken every cycle while the descriptor queue has room; the
// front end compares and updates pad state in the accepting cycle.
// Each report yields 0 to 21 events; the back end emits one beat per cycle
// while the output beat is empty or being popped.
// Reset is synchronous and clears pad state, id counter, queue and output valid flag.
// With pop held low the output beat holds, the back end and then the queue
// fill, and full rises once two descriptors wait.
`default_nettype none

module gamepad_change_event_generator_top #(
    parameter int PAD_COUNT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  gcev_pkg::t_report i_report,
    input  wire logic        pop,
    output logic             empty,
    output gcev_pkg::t_event o_event
);
    import gcev_pkg::*;

    logic   w_accept;
    logic   w_qpush;
    logic   w_qpop;
    t_desc  w_fdesc;
    t_desc  w_bdesc;
    t_qstat w_qstat;

    assign full     = w_qstat.full;
    assign w_accept = push && !w_qstat.full;

    gcev_front #(
        .PAD_COUNT (PAD_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_report (i_report),
        .o_push   (w_qpush),
        .o_desc   (w_fdesc)
    );

    gcev_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_qpush),
        .i_desc  (w_fdesc),
        .i_pop   (w_qpop),
        .o_desc  (w_bdesc),
        .o_stat  (w_qstat)
    );

    gcev_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (w_bdesc),
        .i_qstat (w_qstat),
        .o_qpop  (w_qpop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_event (o_event)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue reports full and empty at once");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_event.last) |=> !empty)
        else $error("event burst broken before its last beat");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qpop |-> !w_qstat.empty)
        else $error("back end pulled from an empty queue");

endmodule

`default_nettype wire

>>> tb/sv/gcev_event_checker.sv
`timescale 1ns / 100ps
// Event checker for the gamepad change event generator: watches the report and
// event queues, predicts the events of each accepted report and compares them.
// Depends on gcev_pkg.

module gcev_event_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  gcev_pkg::t_report i_report,
    input  wire logic        i_pop,
    input  wire logic        i_empty,
    input  gcev_pkg::t_event i_event,
    output int               o_error_count,
    output int               o_pending_count
);
    import gcev_pkg::*;

    localparam int PAD_SLOTS = 4;

    logic        pad_is_connected [PAD_SLOTS];
    logic [31:0] pad_uid_table    [PAD_SLOTS];
    t_rec        stored_reports   [PAD_SLOTS];
    logic [31:0] uid_counter;
    t_event      expected_events [$];
    int          error_count;

    function automatic t_event make_event(input logic [31:0] uid, input logic [1:0] kind,
                                          input logic [3:0] bidx, input logic down,
                                          input logic [1:0] axis, input logic [15:0] ax,
                                          input logic [15:0] ay);
        t_event ev;
        ev              = '0;
        ev.pad_uid      = uid;
        ev.event_kind   = kind;
        ev.button_index = bidx;
        ev.button_down  = down;
        ev.axis_id      = axis;
        ev.axis_x       = ax;
        ev.axis_y       = ay;
        return ev;
    endfunction

    task automatic predict_report(input t_report rep);
        t_event      batch [$];
        t_rec        fresh;
        t_rec        old;
        logic [15:0] changed;
        logic [31:0] uid;
        int          p;
        p = int'(rep.pad_index);
        if (p >= PAD_SLOTS) return;
        if (!rep.pad_present) begin
            if (pad_is_connected[p]) begin
                batch.push_back(make_event(pad_uid_table[p], EV_DISCONNECT, 4'd0, 1'b0,
                                           AX_LTRIG, 16'd0, 16'd0));
                pad_is_connected[p] = 1'b0;
            end
        end else begin
            if (!pad_is_connected[p]) begin
                uid_counter      = uid_counter + 32'd1;
                pad_uid_table[p] = uid_counter;
                batch.push_back(make_event(uid_counter, EV_CONNECT, 4'd0, 1'b0,
                                           AX_LTRIG, 16'd0, 16'd0));
            end
            pad_is_connected[p] = 1'b1;
            uid           = pad_uid_table[p];
            fresh.packet  = rep.packet_number;
            fresh.buttons = rep.buttons;
            fresh.ltrig   = rep.left_trigger;
            fresh.rtrig   = rep.right_trigger;
            fresh.lx      = rep.left_thumb_x;
            fresh.ly      = rep.left_thumb_y;
            fresh.rx      = rep.right_thumb_x;
            fresh.ry      = rep.right_thumb_y;
            old           = stored_reports[p];
            if (fresh != old) begin
                changed = fresh.buttons ^ old.buttons;
                for (int b = 0; b < 16; b++) begin
                    if (changed[b])
                        batch.push_back(make_event(uid, EV_BUTTON, 4'(b), fresh.buttons[b],
                                                   AX_LTRIG, 16'd0, 16'd0));
                end
                if (fresh.ltrig != old.ltrig)
                    batch.push_back(make_event(uid, EV_AXIS, 4'd0, 1'b0, AX_LTRIG,
                                               {8'd0, fresh.ltrig}, 16'd0));
                if (fresh.rtrig != old.rtrig)
                    batch.push_back(make_event(uid, EV_AXIS, 4'd0, 1'b0, AX_RTRIG,
                                               {8'd0, fresh.rtrig}, 16'd0));
                if (fresh.lx != old.lx || fresh.ly != old.ly)
                    batch.push_back(make_event(uid, EV_AXIS, 4'd0, 1'b0, AX_LTHUMB,
                                               fresh.lx, fresh.ly));
                if (fresh.rx != old.rx || fresh.ry != old.ry)
                    batch.push_back(make_event(uid, EV_AXIS, 4'd0, 1'b0, AX_RTHUMB,
                                               fresh.rx, fresh.ry));
                stored_reports[p] = fresh;
            end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_events.push_back(batch[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: event field %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_event(input t_event got);
        t_event want;
        if (expected_events.size() == 0) begin
            $display("%0t ns: unexpected event beat, expected none, actual %h", $time, got);
            error_count++;
            return;
        end
        want = expected_events.pop_front();
        check_field("pad_uid", want.pad_uid, got.pad_uid);
        check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
        check_field("button_index", 32'(want.button_index), 32'(got.button_index));
        check_field("button_down", 32'(want.button_down), 32'(got.button_down));
        check_field("axis_id", 32'(want.axis_id), 32'(got.axis_id));
        check_field("axis_x", 32'(want.axis_x), 32'(got.axis_x));
        check_field("axis_y", 32'(want.axis_y), 32'(got.axis_y));
        check_field("last", 32'(want.last), 32'(got.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAD_SLOTS; p++) begin
                pad_is_connected[p] = 1'b0;
                pad_uid_table[p]    = '0;
                stored_reports[p]   = '0;
            end
            uid_counter = '0;
            expected_events.delete();
        end else begin
            if (i_push && !i_full) predict_report(i_report);
            if (i_pop && !i_empty) check_event(i_event);
        end
        o_error_count   = error_count;
        o_pending_count = expected_events.size();
    end

endmodule

>>> tb/sv/gamepad_change_event_generator_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the gamepad change event generator: clock, reset, report
// stimulus with random gaps, event drain with random stalls, and the verdict.
// Depends on gcev_pkg, gamepad_change_event_generator_top, gcev_event_checker.

module gamepad_change_event_generator_top_tb;
    import gcev_pkg::*;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    logic    pop;
    logic    empty;
    t_report report_in;
    t_event  event_out;
    int      error_count;
    int      pending_events;

    logic    hold_request;
    logic    steady;
    t_report sent_reports [4];

    gamepad_change_event_generator_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_report (report_in),
        .pop      (pop),
        .empty    (empty),
        .o_event  (event_out)
    );

    gcev_event_checker event_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_report        (report_in),
        .i_pop           (pop),
        .i_empty         (empty),
        .i_event         (event_out),
        .o_error_count   (error_count),
        .o_pending_count (pending_events)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int pick_idle();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic t_report make_report(input logic [1:0] pad, input logic present,
                                            input logic [31:0] pkt, input logic [15:0] btn,
                                            input logic [7:0] lt, input logic [7:0] rt,
                                            input logic [15:0] lx, input logic [15:0] ly,
                                            input logic [15:0] rx, input logic [15:0] ry);
        t_report rep;
        rep.pad_index     = pad;
        rep.pad_present   = present;
        rep.packet_number = pkt;
        rep.buttons       = btn;
        rep.left_trigger  = lt;
        rep.right_trigger = rt;
        rep.left_thumb_x  = lx;
        rep.left_thumb_y  = ly;
        rep.right_thumb_x = rx;
        rep.right_thumb_y = ry;
        return rep;
    endfunction

    // mostly small edits of the pad's last report; some repeats, drops and noise
    function automatic t_report random_report();
        t_report     rep;
        logic [1:0]  pad;
        int          r;
        int          flips;
        pad = 2'($urandom_range(0, 3));
        r   = $urandom_range(0, 99);
        rep = make_report(pad, 1'b1, $urandom, 16'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if (r < 10) begin
            rep.pad_present = 1'b0;
        end else if (r < 20) begin
            rep = sent_reports[pad];
        end else if (r < 30) begin
            rep               = sent_reports[pad];
            rep.packet_number = $urandom;
        end else if (r < 80) begin
            rep               = sent_reports[pad];
            rep.packet_number = rep.packet_number + 32'd1;
            flips             = $urandom_range(0, 3);
            repeat (flips) rep.buttons[$urandom_range(0, 15)] ^= 1'b1;
            if ($urandom_range(0, 9) < 3) rep.left_trigger = 8'($urandom);
            if ($urandom_range(0, 9) < 3) rep.right_trigger = 8'($urandom);
            if ($urandom_range(0, 9) < 3) rep.left_thumb_x = 16'($urandom);
            if ($urandom_range(0, 9) < 2) rep.left_thumb_y = 16'($urandom);
            if ($urandom_range(0, 9) < 3) rep.right_thumb_x = 16'($urandom);
            if ($urandom_range(0, 9) < 2) rep.right_thumb_y = 16'($urandom);
        end
        rep.pad_index = pad;
        if (r >= 10) rep.pad_present = 1'b1;
        return rep;
    endfunction

    task automatic send_report(input t_report rep);
        int idle;
        idle = pick_idle();
        if (idle > 0) begin
            push <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        push      <= 1'b1;
        report_in <= rep;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        if (rep.pad_present) sent_reports[rep.pad_index] = rep;
    endtask

    initial begin : event_drain
        int stall;
        int burst;
        bit held;
        held = 1'b0;
        pop  = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request && !held) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            stall = pick_idle();
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            burst = $urandom_range(1, 8);
            repeat (burst) @(negedge i_clk);
        end
    end

    initial begin : report_source
        push         = 1'b0;
        report_in    = '0;
        i_rst_n      = 1'b0;
        hold_request = 1'b0;
        steady       = 1'b0;
        foreach (sent_reports[p]) sent_reports[p] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // absent while never connected
        send_report(make_report(2'd0, 1'b0, 32'h1234_5678, 16'hFFFF, 8'hFF, 8'hFF,
                                16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        // connect with a report equal to the cleared one, then repeat, then packet only
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(2'd0, 1'b1, 32'd1, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(2'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd255,
                                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        // disconnect keeps the stored report; reconnect gives the longest burst
        send_report(make_report(2'd0, 1'b0, 32'd0, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(2'd0, 1'b0, 32'd0, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h0000, 8'd0, 8'd0,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h0001, 8'd0, 8'd0,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h8000, 8'd0, 8'd0,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h8000, 8'd1, 8'd0,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h8000, 8'd1, 8'd255,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // each thumb axis alone
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h8000, 8'd1, 8'd255,
                                16'h0000, 16'h8000, 16'h8000, 16'h8000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h8000, 8'd1, 8'd255,
                                16'h0000, 16'h7FFF, 16'h8000, 16'h8000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h8000, 8'd1, 8'd255,
                                16'h0000, 16'h7FFF, 16'hFFFF, 16'h8000));
        send_report(make_report(2'd0, 1'b1, 32'd0, 16'h8000, 8'd1, 8'd255,
                                16'h0000, 16'h7FFF, 16'hFFFF, 16'h0001));
        // other slots
        send_report(make_report(2'd1, 1'b1, 32'hAAAA_AAAA, 16'hAAAA, 8'h55, 8'hAA,
                                16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_report(make_report(2'd2, 1'b1, 32'd0, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(2'd3, 1'b1, 32'h5555_5555, 16'h5555, 8'hAA, 8'h55,
                                16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_report(make_report(2'd1, 1'b0, 32'd0, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(2'd3, 1'b0, 32'd0, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_report(make_report(2'd1, 1'b1, 32'hAAAA_AAAA, 16'hAAAA, 8'h55, 8'hAA,
                                16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_report(make_report(2'd2, 1'b1, 32'd7, 16'h0000, 8'd0, 8'd0,
                                16'h0000, 16'h0000, 16'h0000, 16'h0000));

        for (int k = 0; k < 400; k++) begin
            if (k == 60) hold_request = 1'b1;
            steady = (k >= 250 && k < 320);
            send_report(random_report());
        end
        steady = 1'b0;
        push <= 1'b0;

        while (pending_events != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
